@@ design/assert_macros.svh @@
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Both macros expect clk and arst_n in scope.
// If the antecedent holds, the consequent must hold in the same cycle.
`define DNSD_ASSERT_SAME(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// If the antecedent holds, the consequent must hold in the next cycle.
`define DNSD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ design/dnsd_pkg.sv @@
`default_nettype none

package dnsd_pkg;

	localparam int PACKET_BYTES_DEF = 4096;
	localparam int MAX_NAME_DEF     = 255;
	localparam int MAX_HOPS_DEF     = 64;

	// Internal offset width: covers a 14-bit pointer target plus one.
	localparam int OFS_W       = 15;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [7:0] PTR_TAG  = 8'hC0;
	localparam logic [7:0] DOT_CHAR = 8'h2E;

	localparam logic ACT_LOAD   = 1'b0;
	localparam logic ACT_DECODE = 1'b1;

	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_PAST_END = 3'd1;
	localparam logic [2:0] ST_BAD_PTR  = 3'd2;
	localparam logic [2:0] ST_TOO_LONG = 3'd3;
	localparam logic [2:0] ST_LOOP     = 3'd4;

	typedef struct packed {
		logic        action;
		logic [11:0] address;
		logic [7:0]  data_byte;
		logic [12:0] packet_length;
	} cmd_t;

	typedef struct packed {
		logic [63:0] text_chunk;
		logic [3:0]  chunk_count;
		logic        last;
		logic [2:0]  status;
		logic [12:0] next_offset;
	} rsp_t;

	// A classified word as it waits in the queue.
	typedef struct packed {
		logic        is_decode;
		logic [11:0] address;
		logic [7:0]  data_byte;
		logic        in_range;
		logic [12:0] limit;
		logic        start_bad;
	} job_t;

	typedef struct packed {
		logic valid;
		job_t job;
	} job_head_t;

endpackage

`default_nettype wire

@@ design/dnsd_ram.sv @@
`default_nettype none

module dnsd_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

@@ design/dnsd_front.sv @@
`default_nettype none

module dnsd_front import dnsd_pkg::*; #(
	parameter int PACKET_BYTES = PACKET_BYTES_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      cmd_valid,
	output logic           cmd_stall,
	input  wire cmd_t      cmd,
	output job_head_t      head,
	input  wire logic      pop
);

	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam logic [OFS_W-1:0] PB = OFS_W'(PACKET_BYTES);

	job_t             entry_q [QUEUE_DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [PW:0]      count_q;
	job_t             job;
	logic [OFS_W-1:0] plen;
	logic [OFS_W-1:0] lim;
	logic             push;

	// The limit is the smaller of packet_length and the store size.
	always_comb begin
		plen          = OFS_W'(cmd.packet_length);
		lim           = (plen < PB) ? plen : PB;
		job.is_decode = (cmd.action == ACT_DECODE);
		job.address   = cmd.address;
		job.data_byte = cmd.data_byte;
		job.in_range  = OFS_W'(cmd.address) < PB;
		job.limit     = lim[12:0];
		job.start_bad = OFS_W'(cmd.address) >= lim;
	end

	assign cmd_stall  = (count_q == (PW+1)'(QUEUE_DEPTH));
	assign push       = cmd_valid && !cmd_stall;
	assign head.valid = (count_q != '0);
	assign head.job   = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

@@ design/dnsd_back.sv @@
`default_nettype none

module dnsd_back import dnsd_pkg::*; #(
	parameter int PACKET_BYTES = PACKET_BYTES_DEF,
	parameter int MAX_NAME     = MAX_NAME_DEF,
	parameter int MAX_HOPS     = MAX_HOPS_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire job_head_t head,
	output logic           pop,
	output logic           rsp_valid,
	input  wire logic      rsp_stall,
	output rsp_t           rsp
);

	localparam int AW = $clog2(PACKET_BYTES);

	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_LEN  = 6'b000010,
		S_PTR  = 6'b000100,
		S_CHAR = 6'b001000,
		S_DOT  = 6'b010000,
		S_FIN  = 6'b100000
	} state_t;

	state_t           state_q, state_d;
	logic [OFS_W-1:0] cursor_q, cursor_d;
	logic [OFS_W-1:0] resume_q, resume_d;
	logic             resume_vld_q, resume_vld_d;
	logic [8:0]       name_len_q, name_len_d;
	logic [6:0]       hop_q, hop_d;
	logic [63:0]      buf_q, buf_d;
	logic [3:0]       fill_q, fill_d;
	logic [5:0]       remain_q, remain_d;
	logic [5:0]       len_hi_q, len_hi_d;
	logic [12:0]      limit_q, limit_d;
	logic [2:0]       fin_status_q, fin_status_d;
	logic [12:0]      fin_next_q, fin_next_d;

	logic             out_valid_q;
	rsp_t             out_q;
	logic             out_free;
	logic             emit;
	rsp_t             emit_word;

	logic             wr_en;
	logic [AW-1:0]    wr_addr;
	logic             rd_en;
	logic [AW-1:0]    rd_addr;
	logic [7:0]       rd_data;

	logic [OFS_W-1:0] lim;
	logic [OFS_W-1:0] cur_inc;
	logic [OFS_W-1:0] ptr_off;
	logic             put_ok;
	logic [7:0]       put_c;
	logic             put_en;

	dnsd_ram #(
		.WIDTH (8),
		.DEPTH (PACKET_BYTES)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (head.job.data_byte),
		.rd_en   (rd_en),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	assign out_free  = !out_valid_q || !rsp_stall;
	assign rsp_valid = out_valid_q;
	assign rsp       = out_q;

	assign lim     = OFS_W'(limit_q);
	assign cur_inc = cursor_q + OFS_W'(1);
	assign ptr_off = OFS_W'({len_hi_q, rd_data});
	assign wr_addr = AW'(head.job.address);

	// A full chunk goes out only when one more character arrives, so a
	// character waits here until the output register can take that chunk.
	assign put_ok = (fill_q != 4'd8) || out_free;

	always_comb begin
		state_d      = state_q;
		cursor_d     = cursor_q;
		resume_d     = resume_q;
		resume_vld_d = resume_vld_q;
		name_len_d   = name_len_q;
		hop_d        = hop_q;
		buf_d        = buf_q;
		fill_d       = fill_q;
		remain_d     = remain_q;
		len_hi_d     = len_hi_q;
		limit_d      = limit_q;
		fin_status_d = fin_status_q;
		fin_next_d   = fin_next_q;
		pop          = 1'b0;
		wr_en        = 1'b0;
		rd_en        = 1'b0;
		rd_addr      = cursor_q[AW-1:0];
		emit         = 1'b0;
		emit_word    = '0;
		put_en       = 1'b0;
		put_c        = DOT_CHAR;

		case (state_q)
			S_IDLE: begin
				if (head.valid) begin
					pop = 1'b1;
					if (!head.job.is_decode) begin
						wr_en = head.job.in_range;
					end else begin
						limit_d      = head.job.limit;
						resume_vld_d = 1'b0;
						resume_d     = '0;
						name_len_d   = '0;
						hop_d        = '0;
						buf_d        = '0;
						fill_d       = '0;
						if (head.job.start_bad) begin
							fin_status_d = ST_PAST_END;
							fin_next_d   = '0;
							state_d      = S_FIN;
						end else begin
							rd_en    = 1'b1;
							rd_addr  = AW'(head.job.address);
							cursor_d = OFS_W'(head.job.address) + OFS_W'(1);
							state_d  = S_LEN;
						end
					end
				end
			end
			S_LEN: begin
				fin_next_d = '0;
				state_d    = S_FIN;
				if (rd_data == 8'd0) begin
					if (name_len_q == '0) begin
						buf_d  = 64'(DOT_CHAR);
						fill_d = 4'd1;
					end
					fin_status_d = ST_OK;
					fin_next_d   = resume_vld_q ? resume_q[12:0] : cursor_q[12:0];
				end else if ((rd_data & PTR_TAG) == PTR_TAG) begin
					if (cursor_q >= lim) begin
						fin_status_d = ST_PAST_END;
					end else begin
						rd_en    = 1'b1;
						cursor_d = cur_inc;
						len_hi_d = rd_data[5:0];
						state_d  = S_PTR;
					end
				end else if ((rd_data & PTR_TAG) != 8'd0) begin
					fin_status_d = ST_BAD_PTR;
				end else if (({1'b0, name_len_q} + 10'(rd_data)) > 10'(MAX_NAME)) begin
					fin_status_d = ST_TOO_LONG;
				end else if ((cursor_q + OFS_W'(rd_data)) > lim) begin
					fin_status_d = ST_PAST_END;
				end else begin
					name_len_d = name_len_q + 9'(rd_data);
					remain_d   = rd_data[5:0];
					rd_en      = 1'b1;
					state_d    = S_CHAR;
				end
			end
			S_PTR: begin
				fin_next_d = '0;
				if (ptr_off >= lim) begin
					fin_status_d = ST_BAD_PTR;
					state_d      = S_FIN;
				end else if (hop_q >= 7'(MAX_HOPS)) begin
					fin_status_d = ST_LOOP;
					state_d      = S_FIN;
				end else begin
					hop_d = hop_q + 7'd1;
					if (!resume_vld_q) begin
						resume_d     = cursor_q;
						resume_vld_d = 1'b1;
					end
					rd_en    = 1'b1;
					rd_addr  = ptr_off[AW-1:0];
					cursor_d = ptr_off + OFS_W'(1);
					state_d  = S_LEN;
				end
			end
			S_CHAR: begin
				if (put_ok) begin
					put_en   = 1'b1;
					put_c    = rd_data;
					cursor_d = cur_inc;
					remain_d = remain_q - 6'd1;
					if (remain_q == 6'd1) begin
						state_d = S_DOT;
					end else begin
						rd_en   = 1'b1;
						rd_addr = cur_inc[AW-1:0];
					end
				end
			end
			S_DOT: begin
				if (put_ok) begin
					put_en = 1'b1;
					put_c  = DOT_CHAR;
					if (cursor_q >= lim) begin
						fin_status_d = ST_PAST_END;
						fin_next_d   = '0;
						state_d      = S_FIN;
					end else begin
						rd_en    = 1'b1;
						cursor_d = cur_inc;
						state_d  = S_LEN;
					end
				end
			end
			S_FIN: begin
				if (out_free) begin
					emit                  = 1'b1;
					emit_word.text_chunk  = buf_q;
					emit_word.chunk_count = fill_q;
					emit_word.last        = 1'b1;
					emit_word.status      = fin_status_q;
					emit_word.next_offset = fin_next_q;
					buf_d                 = '0;
					fill_d                = '0;
					state_d               = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		if (put_en) begin
			if (fill_q == 4'd8) begin
				emit                  = 1'b1;
				emit_word.text_chunk  = buf_q;
				emit_word.chunk_count = 4'd8;
				emit_word.last        = 1'b0;
				emit_word.status      = ST_OK;
				emit_word.next_offset = '0;
				buf_d                 = 64'(put_c);
				fill_d                = 4'd1;
			end else begin
				buf_d[{fill_q[2:0], 3'b000} +: 8] = put_c;
				fill_d = fill_q + 4'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		remain_q <= remain_d;
		len_hi_q <= len_hi_d;
		limit_q  <= limit_d;
		resume_q <= resume_d;
		fin_status_q <= fin_status_d;
		fin_next_q   <= fin_next_d;
		if (emit) begin
			out_q <= emit_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cursor_q     <= '0;
			resume_vld_q <= 1'b0;
			name_len_q   <= '0;
			hop_q        <= '0;
			buf_q        <= '0;
			fill_q       <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q      <= state_d;
			cursor_q     <= cursor_d;
			resume_vld_q <= resume_vld_d;
			name_len_q   <= name_len_d;
			hop_q        <= hop_d;
			buf_q        <= buf_d;
			fill_q       <= fill_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

@@ design/dns_name_decompressor_unit.sv @@
// Channel  Payload  Handshake                 Carries
// cmd      cmd_t    cmd_valid / cmd_stall     byte loads and name decodes
// rsp      rsp_t    rsp_valid / rsp_stall     eight-character text chunks
//
// A load is written into the packet store as it leaves the two-word queue.
// A decode reads the packet store one byte per cycle over the walker's single
// read port while rsp does not hold it, writes a dot after each label and sends
// the last word from the final state. Inner chunks leave alongside a character.
// Reset clears queue, walker and output register; the packet store is not cleared.
// cmd_stall rises only when the queue is full; a stalled rsp word holds the walker
// only when it needs the output register for the next chunk.
`default_nettype none

module dns_name_decompressor_unit import dnsd_pkg::*; #(
	parameter int PACKET_BYTES = PACKET_BYTES_DEF,
	parameter int MAX_NAME     = MAX_NAME_DEF,
	parameter int MAX_HOPS     = MAX_HOPS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic cmd_valid,
	output logic      cmd_stall,
	input  wire cmd_t cmd,
	output logic      rsp_valid,
	input  wire logic rsp_stall,
	output rsp_t      rsp
);

	job_head_t head;
	logic      pop;

	dnsd_front #(
		.PACKET_BYTES (PACKET_BYTES)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.head      (head),
		.pop       (pop)
	);

	dnsd_back #(
		.PACKET_BYTES (PACKET_BYTES),
		.MAX_NAME     (MAX_NAME),
		.MAX_HOPS     (MAX_HOPS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.pop       (pop),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

endmodule

`default_nettype wire

@@ design/dnsd_checker.sv @@
`default_nettype none
`include "assert_macros.svh"

module dnsd_checker import dnsd_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cmd_valid,
	input wire logic cmd_stall,
	input wire cmd_t cmd,
	input wire logic rsp_valid,
	input wire logic rsp_stall,
	input wire rsp_t rsp
);

	logic rsp_mid;
	logic rsp_ok_end;
	logic rsp_err_end;
	logic mid_clean;
	logic ok_count_good;
	logic err_clean;

	assign rsp_mid     = rsp_valid && !rsp.last;
	assign rsp_ok_end  = rsp_valid && rsp.last && (rsp.status == ST_OK);
	assign rsp_err_end = rsp_valid && rsp.last && (rsp.status != ST_OK);

	assign mid_clean     = (rsp.chunk_count == 4'd8) && (rsp.status == ST_OK) &&
		(rsp.next_offset == '0);
	assign ok_count_good = (rsp.chunk_count != 4'd0) && (rsp.chunk_count <= 4'd8);
	assign err_clean     = (rsp.next_offset == '0) && (rsp.status <= ST_LOOP);

	`DNSD_ASSERT_NEXT(a_cmd_hold, cmd_valid && cmd_stall, cmd_valid && $stable(cmd), "cmd moved")
	`DNSD_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp), "rsp moved")
	`DNSD_ASSERT_SAME(a_mid_full, rsp_mid, mid_clean, "inner chunk not full and clean")
	`DNSD_ASSERT_SAME(a_ok_count, rsp_ok_end, ok_count_good, "ok name ends with bad count")
	`DNSD_ASSERT_SAME(a_err_next, rsp_err_end, err_clean, "error end with offset or bad code")

endmodule

bind dns_name_decompressor_unit dnsd_checker u_dnsd_checker (.*);

`default_nettype wire

@@ verif/tb_dns_name_decompressor_unit.sv @@
module tb_dns_name_decompressor_unit;
	timeunit 1ns;
	timeprecision 1ps;
	import dnsd_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;

	// Mirrors the packet store and walks names exactly as the block should.
	class name_scoreboard;
		logic [7:0] store [PACKET_BYTES_DEF];
		bit written [PACKET_BYTES_DEF];
		rsp_t expected_words[$];
		rsp_t scratch[$];
		logic [63:0] chunk_text;
		int chunk_fill;
		int miss_addr;
		int mismatches;
		int words_checked;

		function logic [7:0] fetch(int a);
			if (!written[a] && miss_addr < 0)
				miss_addr = a;
			return written[a] ? store[a] : 8'h00;
		endfunction

		function void push_word(logic [63:0] t, int n, bit l, logic [2:0] st, int nx);
			rsp_t w;
			w.text_chunk = t;
			w.chunk_count = 4'(n);
			w.last = l;
			w.status = st;
			w.next_offset = 13'(nx);
			scratch.push_back(w);
		endfunction

		// A full chunk leaves only when the next character shows up.
		function void add_char(logic [7:0] c);
			if (chunk_fill >= 8) begin
				push_word(chunk_text, 8, 1'b0, ST_OK, 0);
				chunk_text = '0;
				chunk_fill = 0;
			end
			chunk_text[8*chunk_fill +: 8] = c;
			chunk_fill++;
		endfunction

		function void close_name(logic [2:0] st, int nx);
			push_word(chunk_text, chunk_fill, 1'b1, st, (st == ST_OK) ? nx : 0);
			chunk_text = '0;
			chunk_fill = 0;
		endfunction

		function void walk_name(int start, int plen);
			int lim, cur, len, off, nlen, hops, resume;
			bit resumed;
			scratch.delete();
			chunk_text = '0;
			chunk_fill = 0;
			miss_addr = -1;
			lim = (plen < PACKET_BYTES_DEF) ? plen : PACKET_BYTES_DEF;
			cur = start;
			nlen = 0;
			hops = 0;
			resume = 0;
			resumed = 1'b0;
			if (cur >= lim) begin
				close_name(ST_PAST_END, 0);
				return;
			end
			len = fetch(cur);
			cur++;
			while (len != 0) begin
				if ((len & PTR_TAG) == PTR_TAG) begin
					if (cur >= lim) begin
						close_name(ST_PAST_END, 0);
						return;
					end
					off = ((len << 8) | fetch(cur)) & 'h3FFF;
					cur++;
					if (off >= lim) begin
						close_name(ST_BAD_PTR, 0);
						return;
					end
					if (hops >= MAX_HOPS_DEF) begin
						close_name(ST_LOOP, 0);
						return;
					end
					hops++;
					// The offset reported is the one after the first pointer.
					if (!resumed) begin
						resume = cur;
						resumed = 1'b1;
					end
					cur = off;
					len = fetch(cur);
					cur++;
					continue;
				end
				if ((len & PTR_TAG) != 0) begin
					close_name(ST_BAD_PTR, 0);
					return;
				end
				if (nlen + len > MAX_NAME_DEF) begin
					close_name(ST_TOO_LONG, 0);
					return;
				end
				if (cur + len > lim) begin
					close_name(ST_PAST_END, 0);
					return;
				end
				for (int i = 0; i < len; i++)
					add_char(fetch(cur + i));
				add_char(DOT_CHAR);
				nlen += len;
				cur += len;
				if (cur >= lim) begin
					close_name(ST_PAST_END, 0);
					return;
				end
				len = fetch(cur);
				cur++;
			end
			if (nlen == 0)
				add_char(DOT_CHAR);
			close_name(ST_OK, resumed ? resume : cur);
		endfunction

		function int first_unwritten(int start, int plen);
			walk_name(start, plen);
			return miss_addr;
		endfunction

		function void note_cmd(cmd_t c);
			if (c.action == ACT_LOAD) begin
				store[c.address] = c.data_byte;
				written[c.address] = 1'b1;
			end else begin
				walk_name(c.address, c.packet_length);
				foreach (scratch[k])
					expected_words.push_back(scratch[k]);
			end
		endfunction

		function void report(string field, logic [63:0] want, logic [63:0] got);
			mismatches++;
			if (mismatches <= 100)
				$display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
			else if (mismatches == 101)
				$display("Further mismatches are counted but not shown.");
		endfunction

		function void check_word(rsp_t got);
			rsp_t want;
			if (expected_words.size() == 0) begin
				mismatches++;
				$display("%0t: word with nothing expected, expected none, got %h", $time, got);
				return;
			end
			want = expected_words.pop_front();
			words_checked++;
			if (got.text_chunk !== want.text_chunk)
				report("text_chunk", want.text_chunk, got.text_chunk);
			if (got.chunk_count !== want.chunk_count)
				report("chunk_count", 64'(want.chunk_count), 64'(got.chunk_count));
			if (got.last !== want.last)
				report("last", 64'(want.last), 64'(got.last));
			if (got.status !== want.status)
				report("status", 64'(want.status), 64'(got.status));
			if (got.next_offset !== want.next_offset)
				report("next_offset", 64'(want.next_offset), 64'(got.next_offset));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_stall;
	cmd_t cmd = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	rsp_t rsp;

	name_scoreboard sb = new();

	int cycles = 0;
	int n_cmds = 0;
	int n_decodes = 0;
	bit cmd_no_gaps = 1'b0;
	int name_starts[$];

	int stall_left = 0;
	int stall_pick;
	bit stall_now = 1'b0;

	dns_name_decompressor_unit dut (
		.clk,
		.arst_n,
		.cmd_valid,
		.cmd_stall,
		.cmd,
		.rsp_valid,
		.rsp_stall,
		.rsp
	);

	always #1 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Timed out after %0d cycles with %0d words outstanding.", cycles,
				sb.expected_words.size());
			$display("Test completed with failures");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall)
			sb.check_word(rsp);
	end

	// Stall runs and stall-free stretches of random length on the result side.
	always @(negedge clk) begin
		if (stall_left == 0) begin
			stall_pick = $urandom_range(0, 99);
			if (stall_pick < 40) begin
				stall_now = 1'b0;
				stall_left = $urandom_range(1, 6);
			end else if (stall_pick < 55) begin
				stall_now = 1'b0;
				stall_left = $urandom_range(30, 80);
			end else if (stall_pick < 92) begin
				stall_now = 1'b1;
				stall_left = $urandom_range(1, 3);
			end else begin
				stall_now = 1'b1;
				stall_left = $urandom_range(10, 40);
			end
		end
		stall_left--;
		rsp_stall <= stall_now;
	end

	function automatic int pick_gap();
		int r;
		if (cmd_no_gaps)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 88)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 40);
	endfunction

	task automatic send_cmd(cmd_t c);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			cmd_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd <= c;
		cmd_valid <= 1'b1;
		@(posedge clk);
		while (cmd_stall)
			@(posedge clk);
		sb.note_cmd(c);
		n_cmds++;
		if (c.action == ACT_DECODE)
			n_decodes++;
	endtask

	task automatic load_byte(int a, logic [7:0] d);
		cmd_t c;
		c.action = ACT_LOAD;
		c.address = a[11:0];
		c.data_byte = d;
		c.packet_length = 13'($urandom_range(0, 8191));
		send_cmd(c);
	endtask

	task automatic put_byte(inout int at, input logic [7:0] d);
		load_byte(at, d);
		at++;
	endtask

	task automatic put_label(inout int at, input string s);
		put_byte(at, 8'(s.len()));
		for (int i = 0; i < s.len(); i++)
			put_byte(at, s[i]);
	endtask

	// Any byte the walk would reach that was never loaded gets loaded first.
	task automatic decode_at(int start, int plen);
		cmd_t c;
		int hole;
		logic [7:0] fill;
		hole = sb.first_unwritten(start, plen);
		while (hole >= 0) begin
			fill = 8'($urandom_range(0, 255));
			if ($urandom_range(0, 1) == 0)
				fill = 8'h00;
			load_byte(hole, fill);
			hole = sb.first_unwritten(start, plen);
		end
		c.action = ACT_DECODE;
		c.address = start[11:0];
		c.data_byte = 8'($urandom_range(0, 255));
		c.packet_length = plen[12:0];
		send_cmd(c);
	endtask

	function automatic int pick_length(int base, int n);
		int r;
		r = $urandom_range(0, 9);
		if (r < 5)
			return PACKET_BYTES_DEF;
		if (r < 7)
			return $urandom_range(PACKET_BYTES_DEF + 1, 8191);
		if (r == 7)
			return base + n;
		if (r == 8)
			return $urandom_range(base, base + n - 1);
		return $urandom_range(0, base);
	endfunction

	// A name with random labels, ending in the root, in a pointer to an earlier
	// name or sometimes in a pointer to a random offset.
	task automatic random_name();
		logic [7:0] bytes[$];
		int nlabels, lbl, tgt, r, base, again;
		nlabels = $urandom_range(0, 3);
		for (int k = 0; k < nlabels; k++) begin
			lbl = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 63) : $urandom_range(1, 8);
			bytes.push_back(lbl[7:0]);
			repeat (lbl)
				bytes.push_back(8'($urandom_range(0, 255)));
		end
		r = $urandom_range(0, 19);
		if (r < 10 || name_starts.size() == 0) begin
			bytes.push_back(8'h00);
		end else begin
			if (r < 19)
				tgt = name_starts[$urandom_range(0, name_starts.size() - 1)];
			else
				tgt = $urandom_range(0, 16383);
			bytes.push_back(PTR_TAG | {2'b00, tgt[13:8]});
			bytes.push_back(tgt[7:0]);
		end
		base = $urandom_range(100, PACKET_BYTES_DEF - bytes.size());
		foreach (bytes[k])
			load_byte(base + k, bytes[k]);
		name_starts.push_back(base);
		decode_at(base, pick_length(base, bytes.size()));
		again = $urandom_range(0, 2);
		repeat (again) begin
			tgt = name_starts[$urandom_range(0, name_starts.size() - 1)];
			decode_at(tgt, pick_length(tgt, 16));
		end
	endtask

	task automatic broken_bytes();
		int base, n;
		n = $urandom_range(1, 6);
		base = $urandom_range(0, PACKET_BYTES_DEF - n);
		for (int k = 0; k < n; k++)
			load_byte(base + k, 8'($urandom_range(0, 255)));
		decode_at(base, ($urandom_range(0, 1) == 0) ? PACKET_BYTES_DEF : base + n);
	endtask

	initial begin
		int at, r, cmds_before, decodes_before;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		at = 0;
		put_label(at, "example");
		put_label(at, "com");
		put_byte(at, 8'h00);
		put_byte(at, 8'h00);
		put_byte(at, PTR_TAG);
		put_byte(at, 8'd13);
		put_label(at, "foo");
		put_byte(at, PTR_TAG);
		put_byte(at, 8'd0);
		put_byte(at, 8'h40);
		put_byte(at, 8'h80);
		put_byte(at, PTR_TAG);
		put_byte(at, 8'd24);
		put_byte(at, 8'hCF);
		put_byte(at, 8'hFF);
		put_byte(at, 8'hFF);
		put_byte(at, 8'hFF);
		// A 20-byte label whose pointer leads back to itself grows past the name limit.
		put_byte(at, 8'd20);
		repeat (20)
			put_byte(at, 8'($urandom_range(0, 255)));
		put_byte(at, PTR_TAG);
		put_byte(at, 8'd30);
		put_label(at, "abcdefg");
		put_byte(at, 8'h00);
		load_byte(PACKET_BYTES_DEF - 1, 8'h00);

		decode_at(0, PACKET_BYTES_DEF);
		decode_at(13, PACKET_BYTES_DEF);
		decode_at(14, PACKET_BYTES_DEF);
		decode_at(16, PACKET_BYTES_DEF);
		decode_at(22, PACKET_BYTES_DEF);
		decode_at(23, PACKET_BYTES_DEF);
		decode_at(24, PACKET_BYTES_DEF);
		decode_at(26, 100);
		decode_at(28, 8191);
		decode_at(0, 5);
		decode_at(0, 0);
		decode_at(14, 15);
		decode_at(0, 12);
		decode_at(30, PACKET_BYTES_DEF);
		decode_at(53, PACKET_BYTES_DEF);
		decode_at(PACKET_BYTES_DEF - 1, PACKET_BYTES_DEF);
		decode_at(PACKET_BYTES_DEF - 1, 8191);
		decode_at(PACKET_BYTES_DEF - 1, PACKET_BYTES_DEF - 1);
		name_starts.push_back(0);
		name_starts.push_back(13);
		name_starts.push_back(16);

		cmds_before = n_cmds;
		decodes_before = n_decodes;
		while (n_cmds - cmds_before < 20 || n_decodes - decodes_before < 8) begin
			cmd_no_gaps = ($urandom_range(0, 3) == 0);
			r = $urandom_range(0, 19);
			if (r < 14)
				random_name();
			else if (r < 17)
				decode_at($urandom_range(0, PACKET_BYTES_DEF - 1), $urandom_range(0, 8191));
			else
				broken_bytes();
		end

		@(negedge clk);
		cmd_valid <= 1'b0;
		while (sb.expected_words.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);

		$display("Sent %0d words on the command side, %0d of them name decodes.", n_cmds,
			n_decodes);
		$display("Checked %0d text chunks covering ok names, pointers and every error status.",
			sb.words_checked);
		if (sb.mismatches == 0 && sb.expected_words.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end
endmodule
